// ===== design/grid_to_particle_rate_update_macros.svh =====
// assertion macros for the grid-to-particle rate update block
// no dependencies; included by the top level
`ifndef GRID_TO_PARTICLE_RATE_UPDATE_MACROS_SVH
`define GRID_TO_PARTICLE_RATE_UPDATE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define G2P_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define G2P_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define G2P_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define G2P_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/g2p_pkg.sv =====
// shared widths, limits and status types for the grid-to-particle rate update
// no dependencies
`timescale 1ns / 1ps

package g2p_pkg;

   localparam int VAL_W     = 32;
   localparam int MASS_W    = 32;
   localparam int WGT_W     = 17;
   localparam int DT_W      = 32;
   localparam int ACC_W     = 48;
   localparam int NUM_W     = VAL_W + WGT_W;
   localparam int NUM_COMP  = 3;
   localparam int COMP_W    = 2;

   // divider: radix-4 restoring, two quotient bits per cycle
   localparam int DIV_STEPS  = 2;
   localparam int DIV_ITERS  = ACC_W / DIV_STEPS;
   localparam int DIV_ITER_W = $clog2(DIV_ITERS);

   // output scaling: acc * dt >> (40 - FRAC_BITS)
   localparam int FRAC_BITS = 16;
   localparam int FIN_SHIFT = 40 - FRAC_BITS;
   localparam int HALF_W    = ACC_W / 2;
   localparam int PART_W    = HALF_W + DT_W;
   localparam int PROD_W    = ACC_W + DT_W;
   localparam int MAG_W     = VAL_W + 2;
   localparam int SUM_W     = VAL_W + 4;

   localparam int MAX_CONTRIB_DEFAULT = 64;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [MAG_W-1:0] MAG_LIMIT = {2'b01, {(MAG_W-2){1'b0}}};

   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [VAL_W-1:0] val_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic sat;
   } fin_stat_type;

endpackage

// ===== design/g2p_divider.sv =====
// iterative unsigned divider, 48-bit dividend by 32-bit divisor, two bits per cycle
// depends on g2p_pkg
`timescale 1ns / 1ps

module g2p_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [g2p_pkg::ACC_W-1:0]    dividend,
   input  logic [g2p_pkg::MASS_W-1:0]   divisor,
   output logic [g2p_pkg::ACC_W-1:0]    quotient,
   output g2p_pkg::div_stat_type        stat
);
   import g2p_pkg::*;

   logic [MASS_W-1:0]     rem_ff, rem_in;
   logic [ACC_W-1:0]      quo_ff, quo_in;
   logic [DIV_ITER_W-1:0] iter_ff, iter_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [MASS_W-1:0] rem_v;
   logic [ACC_W-1:0]  quo_v;
   logic [MASS_W:0]   trial;
   logic [MASS_W:0]   diff;
   logic              ge;

   // restoring steps, dividend shifts out the top while quotient bits shift in
   always_comb begin
      rem_v = rem_ff;
      quo_v = quo_ff;
      trial = '0;
      diff  = '0;
      ge    = 1'b0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {rem_v, quo_v[ACC_W-1]};
         diff  = trial - {1'b0, divisor};
         ge    = trial >= {1'b0, divisor};
         rem_v = ge ? diff[MASS_W-1:0] : trial[MASS_W-1:0];
         quo_v = {quo_v[ACC_W-2:0], ge};
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = rem_v;
         quo_in  = quo_v;
         iter_in = iter_ff + 1'b1;
         if (iter_ff == DIV_ITER_W'(DIV_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         iter_ff <= iter_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== design/g2p_finish.sv =====
// output stage: old + trunc(acc * dt >> shift), clipped to 32 bits
// one 24x32 multiplier used twice per component; depends on g2p_pkg
`timescale 1ns / 1ps

module g2p_finish (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  g2p_pkg::acc_type           acc,
   input  g2p_pkg::val_type           old,
   input  logic [g2p_pkg::DT_W-1:0]   time_step,
   output g2p_pkg::val_type           result,
   output g2p_pkg::fin_stat_type      stat
);
   import g2p_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_HI   = 3'd1;
   localparam logic [2:0] PH_LO   = 3'd2;
   localparam logic [2:0] PH_SHF  = 3'd3;
   localparam logic [2:0] PH_ADD  = 3'd4;

   logic [2:0]        phase_ff, phase_in;
   logic [ACC_W-1:0]  a_ff, a_in;
   logic              neg_ff, neg_in;
   logic [VAL_W-1:0]  old_ff, old_in;
   logic [PART_W-1:0] p_hi_ff, p_hi_in;
   logic [PART_W-1:0] p_lo_ff, p_lo_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              big_ff, big_in;
   logic [VAL_W-1:0]  res_ff, res_in;
   logic              sat_ff, sat_in;
   logic              done_ff, done_in;

   logic [HALF_W-1:0] mul_a;
   logic [PART_W-1:0] mul_p;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] mag_full;
   logic [SUM_W-1:0]  mag_s;
   logic [SUM_W-1:0]  sum;
   logic              sum_ok;

   // shared multiplier: upper half first, then lower half
   assign mul_a = (phase_ff == PH_HI) ? a_ff[ACC_W-1:HALF_W] : a_ff[HALF_W-1:0];
   assign mul_p = {{DT_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, time_step};

   assign prod     = ({{(PROD_W-PART_W){1'b0}}, p_hi_ff} << HALF_W)
                   + {{(PROD_W-PART_W){1'b0}}, p_lo_ff};
   assign mag_full = prod >> FIN_SHIFT;

   assign mag_s  = {{(SUM_W-MAG_W){1'b0}}, mag_ff};
   assign sum    = {{(SUM_W-VAL_W){old_ff[VAL_W-1]}}, old_ff}
                 + (neg_ff ? (SUM_W'(0) - mag_s) : mag_s);
   assign sum_ok = (&sum[SUM_W-1:VAL_W-1]) || !(|sum[SUM_W-1:VAL_W-1]);

   always_comb begin
      phase_in = phase_ff;
      a_in     = a_ff;
      neg_in   = neg_ff;
      old_in   = old_ff;
      p_hi_in  = p_hi_ff;
      p_lo_in  = p_lo_ff;
      mag_in   = mag_ff;
      big_in   = big_ff;
      res_in   = res_ff;
      sat_in   = sat_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               neg_in   = acc[ACC_W-1];
               a_in     = acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;
               old_in   = old;
               phase_in = PH_HI;
            end
         end
         PH_HI: begin
            p_hi_in  = mul_p;
            phase_in = PH_LO;
         end
         PH_LO: begin
            p_lo_in  = mul_p;
            phase_in = PH_SHF;
         end
         PH_SHF: begin
            mag_in   = mag_full[MAG_W-1:0];
            big_in   = (|mag_full[PROD_W-1:MAG_W]) || (mag_full[MAG_W-1:0] > MAG_LIMIT);
            phase_in = PH_ADD;
         end
         PH_ADD: begin
            if (big_ff) begin
               res_in = neg_ff ? VAL_MIN : VAL_MAX;
               sat_in = 1'b1;
            end else if (!sum_ok) begin
               res_in = sum[SUM_W-1] ? VAL_MIN : VAL_MAX;
               sat_in = 1'b1;
            end else begin
               res_in = sum[VAL_W-1:0];
               sat_in = 1'b0;
            end
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      a_ff    <= a_in;
      neg_ff  <= neg_in;
      old_ff  <= old_in;
      p_hi_ff <= p_hi_in;
      p_lo_ff <= p_lo_in;
      mag_ff  <= mag_in;
      big_ff  <= big_in;
      res_ff  <= res_in;
      sat_ff  <= sat_in;
   end

   assign result    = res_ff;
   assign stat.busy = (phase_ff != PH_IDLE);
   assign stat.done = done_ff;
   assign stat.sat  = sat_ff;

endmodule

// ===== design/grid_to_particle_rate_update.sv =====
// grid-to-particle rate update: top level with sequencer, accumulator and output register
// depends on g2p_pkg, g2p_divider, g2p_finish and the assertion macro header
//
// usage
//  - req_* channel: one transfer per contributing grid node of a particle; req_last_node
//    marks the final node. rsp_* channel: one transfer per particle, issued after the
//    last node. csr_wr_en/csr_wr_data load the time step; the user must do so only
//    while the block is idle, as the block itself does not enforce this.
//  - a node with nonzero mass (within the first MAX_CONTRIB of its particle) runs
//    vec * weight / mass for x, y, z in turn through one shared radix-4 divider, holding
//    the block for a multiply, divider start, divider iterations and add per component;
//    a node that adds nothing and is not last leaves the sequencer idle.
//  - a last node then runs the output scalings (one 24x32 multiplier used twice per
//    component) and loads the output register, which raises rsp_valid.
//  - req_ready is high only while the sequencer is idle; the next node may be taken
//    while a result still sits in the output register.
//  - if the receiver stalls, the finished result holds in the output register and the
//    next particle's last node waits before its result is loaded.
//  - reset (synchronous) clears the accumulators, contribution count, time step and
//    all valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
`include "grid_to_particle_rate_update_macros.svh"

module grid_to_particle_rate_update #(
   parameter int MAX_CONTRIB = g2p_pkg::MAX_CONTRIB_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [g2p_pkg::DT_W-1:0]      csr_wr_data,
   // node input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [g2p_pkg::VAL_W-1:0] req_node_vec_x,
   input  logic signed [g2p_pkg::VAL_W-1:0] req_node_vec_y,
   input  logic signed [g2p_pkg::VAL_W-1:0] req_node_vec_z,
   input  logic [g2p_pkg::MASS_W-1:0]    req_node_mass,
   input  logic [g2p_pkg::WGT_W-1:0]     req_shape_weight,
   input  logic signed [g2p_pkg::VAL_W-1:0] req_old_x,
   input  logic signed [g2p_pkg::VAL_W-1:0] req_old_y,
   input  logic signed [g2p_pkg::VAL_W-1:0] req_old_z,
   input  logic                          req_last_node,
   // particle result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [g2p_pkg::VAL_W-1:0] rsp_new_x,
   output logic signed [g2p_pkg::VAL_W-1:0] rsp_new_y,
   output logic signed [g2p_pkg::VAL_W-1:0] rsp_new_z,
   output logic                          rsp_saturated
);
   import g2p_pkg::*;

   localparam int CNT_W = $clog2(MAX_CONTRIB + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_DIVGO = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_ACC   = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;
   localparam logic [2:0] S_FWAIT = 3'd6;
   localparam logic [2:0] S_PUT   = 3'd7;

   localparam logic [COMP_W-1:0] COMP_LAST = COMP_W'(NUM_COMP - 1);

   // control
   logic [2:0]        state_ff, state_in;
   logic [COMP_W-1:0] comp_ff, comp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DT_W-1:0]   dt_ff, dt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // latched node
   val_type           vec_ff [NUM_COMP], vec_in [NUM_COMP];
   val_type           old_ff [NUM_COMP], old_in [NUM_COMP];
   logic [MASS_W-1:0] mass_ff, mass_in;
   logic [WGT_W-1:0]  wgt_ff, wgt_in;
   logic              last_ff, last_in;

   // datapath
   logic [NUM_W-1:0]  prod_ff, prod_in;
   logic              neg_ff, neg_in;
   acc_type           term_ff, term_in;
   acc_type           acc_ff [NUM_COMP], acc_in [NUM_COMP];
   val_type           new_ff [NUM_COMP], new_in [NUM_COMP];
   logic              sat_ff, sat_in;

   // output register
   val_type           rsp_x_ff, rsp_x_in;
   val_type           rsp_y_ff, rsp_y_in;
   val_type           rsp_z_ff, rsp_z_in;
   logic              rsp_sat_ff, rsp_sat_in;

   logic              accept;
   logic              do_acc;
   logic              cnt_open;
   logic              put_go;
   logic              div_start;
   logic [ACC_W-1:0]  div_dividend;
   logic [ACC_W-1:0]  quotient;
   div_stat_type      div_stat;
   logic              fin_start;
   val_type           fin_result;
   fin_stat_type      fin_stat;
   logic [NUM_W-1:0]  num_mag;
   logic [ACC_W:0]    acc_sum;
   logic [ACC_W-1:0]  term_clip;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign cnt_open  = (cnt_ff < CNT_W'(MAX_CONTRIB));
   assign do_acc    = cnt_open && (req_node_mass != '0);
   // load the output register once it is empty or being drained this cycle
   assign put_go    = (state_ff == S_PUT) && (!rsp_valid_ff || rsp_ready);

   // magnitude of vec * weight for the divider
   assign num_mag      = prod_ff[NUM_W-1] ? (NUM_W'(0) - prod_ff) : prod_ff;
   assign div_dividend = num_mag[ACC_W-1:0];
   assign div_start    = (state_ff == S_DIVGO);

   // signed quotient clipped to the 48-bit range
   always_comb begin
      if (!neg_ff) begin
         term_clip = quotient[ACC_W-1] ? ACC_MAX : quotient;
      end else if (quotient[ACC_W-1] && (|quotient[ACC_W-2:0])) begin
         term_clip = ACC_MIN;
      end else begin
         term_clip = ACC_W'(0) - quotient;
      end
   end

   // accumulator add, clipped on overflow
   assign acc_sum = {acc_ff[comp_ff][ACC_W-1], acc_ff[comp_ff]}
                  + {term_ff[ACC_W-1], term_ff};

   assign fin_start = (state_ff == S_FIN);

   g2p_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (mass_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   g2p_finish u_fin (
      .clock     (clock),
      .reset     (reset),
      .start     (fin_start),
      .acc       (acc_ff[comp_ff]),
      .old       (old_ff[comp_ff]),
      .time_step (dt_ff),
      .result    (fin_result),
      .stat      (fin_stat)
   );

   // sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      comp_in      = comp_ff;
      cnt_in       = cnt_ff;
      dt_in        = csr_wr_en ? csr_wr_data : dt_ff;
      vec_in       = vec_ff;
      old_in       = old_ff;
      mass_in      = mass_ff;
      wgt_in       = wgt_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      new_in       = new_ff;
      sat_in       = sat_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               vec_in[0] = req_node_vec_x;
               vec_in[1] = req_node_vec_y;
               vec_in[2] = req_node_vec_z;
               old_in[0] = req_old_x;
               old_in[1] = req_old_y;
               old_in[2] = req_old_z;
               mass_in   = req_node_mass;
               wgt_in    = req_shape_weight;
               last_in   = req_last_node;
               comp_in   = '0;
               sat_in    = 1'b0;
               // count saturates at the cap; a last node restarts it
               if (req_last_node) begin
                  cnt_in = '0;
               end else if (cnt_open) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (do_acc) begin
                  state_in = S_MUL;
               end else if (req_last_node) begin
                  state_in = S_FIN;
               end
            end
         end
         S_MUL: begin
            prod_in  = NUM_W'($signed(vec_ff[comp_ff]) * $signed({1'b0, wgt_ff}));
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            neg_in   = prod_ff[NUM_W-1];
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               term_in  = term_clip;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
               acc_in[comp_ff] = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
               acc_in[comp_ff] = acc_sum[ACC_W-1:0];
            end
            if (comp_ff == COMP_LAST) begin
               comp_in  = '0;
               state_in = last_ff ? S_FIN : S_IDLE;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_FIN: begin
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            if (fin_stat.done) begin
               new_in[comp_ff] = fin_result;
               sat_in          = sat_ff | fin_stat.sat;
               if (comp_ff == COMP_LAST) begin
                  state_in = S_PUT;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = S_FIN;
               end
            end
         end
         S_PUT: begin
            if (put_go) begin
               rsp_x_in     = new_ff[0];
               rsp_y_in     = new_ff[1];
               rsp_z_in     = new_ff[2];
               rsp_sat_in   = sat_ff;
               rsp_valid_in = 1'b1;
               for (int c = 0; c < NUM_COMP; c++) begin
                  acc_in[c] = '0;
               end
               comp_in  = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         comp_ff      <= '0;
         cnt_ff       <= '0;
         dt_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_COMP; c++) begin
            acc_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         comp_ff      <= comp_in;
         cnt_ff       <= cnt_in;
         dt_ff        <= dt_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
      vec_ff     <= vec_in;
      old_ff     <= old_in;
      mass_ff    <= mass_in;
      wgt_ff     <= wgt_in;
      last_ff    <= last_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      term_ff    <= term_in;
      new_ff     <= new_in;
      sat_ff     <= sat_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_x     = rsp_x_ff;
   assign rsp_new_y     = rsp_y_ff;
   assign rsp_new_z     = rsp_z_ff;
   assign rsp_saturated = rsp_sat_ff;

   // both shared units sit quiet whenever the sequencer takes a new node
   `G2P_ASSERT_IMPLIES(a_units_quiet, clock, reset, state_ff == S_IDLE, !div_stat.busy && !fin_stat.busy, "arithmetic unit busy while sequencer idle")
   // contribution count never passes the cap
   `G2P_ASSERT_IMPLIES(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_CONTRIB), "contribution count above cap")
   // a result only appears from the output load step
   `G2P_ASSERT_IMPLIES(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_PUT, "result raised outside output load")
   // accumulators are clear after each particle
   `G2P_ASSERT_NEXT(a_acc_clear, clock, reset, put_go, acc_ff[0] == '0 && acc_ff[1] == '0 && acc_ff[2] == '0, "accumulator not cleared after result")

endmodule

// ===== dv/grid_to_particle_rate_update_tb.sv =====
// self-checking testbench for the grid-to-particle rate update block
// holds a fixed-point predictor and scoreboard class, drives valid/ready stimulus with stalls
// depends on g2p_pkg and the grid_to_particle_rate_update rtl
`timescale 1ns / 1ps

module grid_to_particle_rate_update_tb;
   import g2p_pkg::*;

   // contribution limit handed to the block, mirrored by the predictor
   localparam int NODE_LIMIT = MAX_CONTRIB_DEFAULT;
   // rate has 16 fraction bits, dt 24, result FRAC_BITS: rate * dt >> (40 - FRAC_BITS)
   localparam int SCALE_SHIFT = 40 - FRAC_BITS;
   localparam longint RATE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint RATE_MIN = -RATE_MAX - 1;
   // any value well past the 32-bit range, used when the scaled rate is huge
   localparam longint FAR_OUT = 64'sh0000_0100_0000_0000;
   localparam longint OUT_MAX = 64'sd2147483647;
   localparam longint OUT_MIN = -64'sd2147483648;
   // settle wait, comfortably longer than a last node takes after its transfer
   localparam int SETTLE_CYCLES = 150;
   // long receiver hold-off, enough for several nodes to queue up behind a held result
   localparam int HOLD_CYCLES = 700;
   // longest legal quiet stretch is the hold-off plus one last node, so this is generous
   localparam int IDLE_LIMIT = 4000;

   typedef struct packed {
      logic [2:0][VAL_W-1:0] vec;
      logic [MASS_W-1:0]     mass;
      logic [WGT_W-1:0]      weight;
      logic [2:0][VAL_W-1:0] old;
      logic                  last_node;
   } grid_node_type;

   typedef struct packed {
      logic [2:0][VAL_W-1:0] value;
      logic                  saturated;
   } particle_result_type;

   // predictor of the rate accumulation plus the queue of particle updates still owed
   class g2p_update_scoreboard;
      longint              rate_acc [3];
      int unsigned         node_count;
      logic [DT_W-1:0]     dt_value;
      particle_result_type owed_q [$];
      int unsigned         mismatches;

      function new();
         int c;
         for (c = 0; c < 3; c++) rate_acc[c] = 0;
         node_count = 0;
         dt_value   = '0;
         mismatches = 0;
      endfunction

      function void set_time_step(logic [DT_W-1:0] v);
         dt_value = v;
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction

      function longint clip_rate(longint v);
         if (v > RATE_MAX) return RATE_MAX;
         if (v < RATE_MIN) return RATE_MIN;
         return v;
      endfunction

      // vec * weight / mass, truncated toward zero, clipped to 48 bits
      function longint node_term(logic [VAL_W-1:0] v, logic [WGT_W-1:0] w,
                                 logic [MASS_W-1:0] m);
         longint          num;
         longint unsigned mag;
         longint unsigned quo;
         num = longint'($signed(v)) * longint'(w);
         if (num < 0) mag = -num;
         else mag = num;
         quo = mag / m;
         if (num < 0) return clip_rate(-longint'(quo));
         return clip_rate(longint'(quo));
      endfunction

      // old + trunc(rate * dt >> shift), clipped; msb of the result flags the clip
      function logic [VAL_W:0] scaled_value(longint rate, logic [VAL_W-1:0] old);
         logic [127:0]    prod;
         logic [127:0]    mag;
         longint unsigned a;
         longint          total;
         logic            clipped;
         if (rate < 0) a = -rate;
         else a = rate;
         prod = {64'd0, a} * {96'd0, dt_value};
         mag  = prod >> SCALE_SHIFT;
         if (mag > 128'h2_0000_0000) begin
            total = (rate < 0) ? -FAR_OUT : FAR_OUT;
         end else if (rate < 0) begin
            total = longint'($signed(old)) - longint'(mag[63:0]);
         end else begin
            total = longint'($signed(old)) + longint'(mag[63:0]);
         end
         clipped = 1'b0;
         if (total > OUT_MAX) begin
            total   = OUT_MAX;
            clipped = 1'b1;
         end
         if (total < OUT_MIN) begin
            total   = OUT_MIN;
            clipped = 1'b1;
         end
         return {clipped, total[VAL_W-1:0]};
      endfunction

      // called once per accepted node; returns 1 when the node was not simply ignored
      function bit note_node(grid_node_type n);
         particle_result_type res;
         logic [VAL_W:0]      one;
         bit                  useful;
         int                  c;
         useful = n.last_node;
         if (node_count < NODE_LIMIT) begin
            node_count++;
            if (n.mass != 0) begin
               for (c = 0; c < 3; c++)
                  rate_acc[c] = clip_rate(rate_acc[c] +
                                          node_term(n.vec[c], n.weight, n.mass));
               useful = 1'b1;
            end
         end
         if (n.last_node) begin
            res.saturated = 1'b0;
            for (c = 0; c < 3; c++) begin
               one            = scaled_value(rate_acc[c], n.old[c]);
               res.value[c]   = one[VAL_W-1:0];
               res.saturated |= one[VAL_W];
               rate_acc[c]    = 0;
            end
            node_count = 0;
            owed_q.push_back(res);
         end
         return useful;
      endfunction

      function void check_particle(particle_result_type got);
         particle_result_type want;
         int                  c;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected particle result x=%0d y=%0d z=%0d saturated=%0b",
                     $time, $signed(got.value[0]), $signed(got.value[1]),
                     $signed(got.value[2]), got.saturated);
            mismatches++;
            return;
         end
         want = owed_q.pop_front();
         for (c = 0; c < 3; c++) begin
            if (got.value[c] !== want.value[c]) begin
               $display("%0t: new_%s mismatch: expected %0d, actual %0d", $time,
                        (c == 0) ? "x" : ((c == 1) ? "y" : "z"),
                        $signed(want.value[c]), $signed(got.value[c]));
               mismatches++;
            end
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch: expected %0b, actual %0b", $time,
                     want.saturated, got.saturated);
            mismatches++;
         end
      endfunction
   endclass

   // clock, reset and block inputs, all known from time zero
   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  csr_wr_en        = 1'b0;
   logic [DT_W-1:0]       csr_wr_data      = '0;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [VAL_W-1:0]      req_node_vec_x   = '0;
   logic [VAL_W-1:0]      req_node_vec_y   = '0;
   logic [VAL_W-1:0]      req_node_vec_z   = '0;
   logic [MASS_W-1:0]     req_node_mass    = '0;
   logic [WGT_W-1:0]      req_shape_weight = '0;
   logic [VAL_W-1:0]      req_old_x        = '0;
   logic [VAL_W-1:0]      req_old_y        = '0;
   logic [VAL_W-1:0]      req_old_z        = '0;
   logic                  req_last_node    = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic signed [VAL_W-1:0] rsp_new_x;
   logic signed [VAL_W-1:0] rsp_new_y;
   logic signed [VAL_W-1:0] rsp_new_z;
   logic                  rsp_saturated;

   g2p_update_scoreboard board;
   bit          no_idle         = 1'b0;  // both sides run without gaps while set
   bit          hold_request    = 1'b0;  // asks the receiver for one long hold-off
   bit          particle_open   = 1'b0;  // a particle has nodes but no last node yet
   int unsigned effective_nodes = 0;     // accepted nodes that accumulated or finished
   int unsigned idle_cycles     = 0;

   always #2 clock = ~clock;

   grid_to_particle_rate_update #(
      .MAX_CONTRIB (NODE_LIMIT)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_node_vec_x   (req_node_vec_x),
      .req_node_vec_y   (req_node_vec_y),
      .req_node_vec_z   (req_node_vec_z),
      .req_node_mass    (req_node_mass),
      .req_shape_weight (req_shape_weight),
      .req_old_x        (req_old_x),
      .req_old_y        (req_old_y),
      .req_old_z        (req_old_z),
      .req_last_node    (req_last_node),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_new_x        (rsp_new_x),
      .rsp_new_y        (rsp_new_y),
      .rsp_new_z        (rsp_new_z),
      .rsp_saturated    (rsp_saturated)
   );

   // mostly small signed values, with the corners and full-range noise mixed in
   function automatic logic [VAL_W-1:0] pick_value();
      logic [VAL_W-1:0] mag;
      logic [VAL_W-1:0] v;
      case ($urandom_range(0, 15))
         0: v = VAL_MAX;
         1: v = VAL_MIN;
         2: v = '0;
         3: v = '1;
         4, 5, 6, 7, 8, 9: begin
            mag = $urandom_range(0, 32'h003F_FFFF);
            v   = $urandom_range(0, 1) ? -mag : mag;
         end
         default: v = $urandom();
      endcase
      return v;
   endfunction

   function automatic grid_node_type random_node(input bit last);
      grid_node_type n;
      int            c;
      for (c = 0; c < 3; c++) begin
         n.vec[c] = pick_value();
         n.old[c] = pick_value();
      end
      // zero mass skips the node; tiny masses blow up the rate and hit the clip
      case ($urandom_range(0, 15))
         0: n.mass = '0;
         1: n.mass = 32'h0000_0001;
         2: n.mass = '1;
         3: n.mass = $urandom_range(1, 255);
         4, 5, 6, 7, 8, 9, 10, 11: n.mass = $urandom_range(32'h1000, 32'h0100_0000);
         default: n.mass = $urandom();
      endcase
      // weights above one are legal, the full 17 bits get exercised
      case ($urandom_range(0, 15))
         0: n.weight = '0;
         1: n.weight = 17'h1_0000;
         2: n.weight = '1;
         3: n.weight = $urandom_range(17'h1_0001, 17'h1_FFFF);
         default: n.weight = $urandom_range(0, 17'h1_0000);
      endcase
      n.last_node = last;
      return n;
   endfunction

   function automatic grid_node_type node_of(
      input logic [VAL_W-1:0] vx, input logic [VAL_W-1:0] vy, input logic [VAL_W-1:0] vz,
      input logic [MASS_W-1:0] m, input logic [WGT_W-1:0] w,
      input logic [VAL_W-1:0] ox, input logic [VAL_W-1:0] oy, input logic [VAL_W-1:0] oz,
      input logic last);
      grid_node_type n;
      n.vec       = {vz, vy, vx};
      n.mass      = m;
      n.weight    = w;
      n.old       = {oz, oy, ox};
      n.last_node = last;
      return n;
   endfunction

   // one node transfer: optional gap with valid low, then hold valid until ready
   task automatic send_node(input grid_node_type n);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_node_vec_x   <= n.vec[0];
      req_node_vec_y   <= n.vec[1];
      req_node_vec_z   <= n.vec[2];
      req_node_mass    <= n.mass;
      req_shape_weight <= n.weight;
      req_old_x        <= n.old[0];
      req_old_y        <= n.old[1];
      req_old_z        <= n.old[2];
      req_last_node    <= n.last_node;
      do @(posedge clock); while (!req_ready);
      if (board.note_node(n)) effective_nodes++;
      particle_open = !n.last_node;
   endtask

   // sender stops, every owed result comes back, then the block gets time to go idle
   task automatic settle_block();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // time step write; only issued while the block is idle
   task automatic load_time_step(input logic [DT_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_time_step(v);
   endtask

   // one time-step setting with random particles; most are well formed, a few are
   // runs of nodes with random last flags
   task automatic run_phase(input int unsigned target, input logic [DT_W-1:0] dt,
                            input bit quiet, input bit squeeze, input bit long_run);
      int unsigned   first;
      int unsigned   pick;
      int unsigned   count;
      int unsigned   i;
      grid_node_type n;
      load_time_step(dt);
      no_idle = quiet;
      if (squeeze) hold_request = 1'b1;
      // a particle past the contribution limit: cheap zero-mass filler up front, the
      // node right at the limit accumulates, everything after it must be dropped
      if (long_run) begin
         count = NODE_LIMIT + $urandom_range(1, 4);
         for (i = 0; i < count; i++) begin
            n = random_node(i == count - 1);
            if (i < NODE_LIMIT - 1 && $urandom_range(0, 7) != 0) n.mass = '0;
            else if (n.mass == 0) n.mass = 32'h0001_0000;
            send_node(n);
         end
      end
      first = effective_nodes;
      while (effective_nodes - first < target) begin
         pick  = $urandom_range(0, 99);
         count = (pick < 88) ? $urandom_range(1, 8) : $urandom_range(1, 6);
         for (i = 0; i < count; i++)
            send_node(random_node((pick < 88) ? (i == count - 1)
                                              : ($urandom_range(0, 2) == 0)));
      end
      if (particle_open) send_node(random_node(1'b1));
      settle_block();
   endtask

   // result side: random stalls, sometimes ready ahead of valid, sometimes after it
   initial begin : result_sink
      int unsigned         stall;
      particle_result_type got;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            // long hold-off so the output register fills and the input backs up
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 13);
         if (stall != 0 && $urandom_range(0, 1) == 1) begin
            rsp_ready <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (stall) @(posedge clock);
         end else if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.value[0]  = rsp_new_x;
         got.value[1]  = rsp_new_y;
         got.value[2]  = rsp_new_z;
         got.saturated = rsp_saturated;
         board.check_particle(got);
      end
   end

   // watchdog: any cycle with a transfer on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero time step: results equal the old values, even with a clipped rate
      load_time_step('0);
      send_node(node_of(VAL_MAX, VAL_MIN, 0, 1, 17'h1_FFFF, VAL_MAX, VAL_MIN, 0, 1));
      send_node(node_of(32'h0001_0000, -65536, 0, 0, 17'h1_0000, 12345, -1, 1, 1));
      settle_block();

      // time step of one
      load_time_step(32'h0100_0000);
      // vector of one, minus one and one half over unit mass and weight
      send_node(node_of(32'h0001_0000, -65536, 32'h0000_8000, 32'h0001_0000, 17'h1_0000,
                        0, 0, 0, 1));
      // single terms clip at 48 bits, then the running sum clips too
      send_node(node_of(VAL_MAX, VAL_MIN, VAL_MAX, 1, 17'h1_FFFF, 0, 0, 0, 0));
      send_node(node_of(VAL_MAX, VAL_MIN, VAL_MAX, 1, 17'h1_FFFF, 0, 0, 0, 0));
      // zero-mass last node still flushes the clipped rate, outputs saturate
      send_node(node_of(0, 0, 0, 0, 0, VAL_MIN, VAL_MAX, 0, 1));
      // zero-mass node mid-particle adds nothing
      send_node(node_of(5 << 16, 7 << 16, -(3 << 16), 0, 17'h1_0000, 0, 0, 0, 0));
      // largest mass: quotients truncate toward zero
      send_node(node_of(VAL_MIN, -1, 1, 32'hFFFF_FFFF, 1, 0, 0, 0, 0));
      // zero weight
      send_node(node_of(123 << 16, -(7 << 16), 3, 2 << 16, 0, 0, 0, 0, 0));
      // thirds do not divide evenly; old z at the top end takes a negative rate, no clip
      send_node(node_of(1 << 16, 1 << 16, -(1 << 16), 3 << 16, 17'h1_0000,
                        10, -10, VAL_MAX, 1));
      // weight slightly above one
      send_node(node_of(-1, 1, -(5 << 16), 1 << 16, 17'h1_0001, VAL_MIN, VAL_MAX,
                        -(1 << 16), 1));
      settle_block();

      // largest time step: tiny rates push old values near the limits over the edge
      load_time_step(32'hFFFF_FFFF);
      send_node(node_of(1, -1, 0, 1 << 16, 17'h1_0000, VAL_MAX - 5, VAL_MIN + 5, 0, 1));
      send_node(node_of(-(1 << 16), 1 << 16, 100, 1 << 16, 17'h1_0000, 0, 0, 0, 1));
      send_node(node_of(VAL_MAX, VAL_MAX, VAL_MAX, 0, 0, VAL_MAX, VAL_MIN, '1, 1));
      settle_block();

      // random phases across time-step settings; one with a long receiver hold-off,
      // one with both sides running back to back, one past the contribution limit
      run_phase(80, 32'h0100_0000, 1'b0, 1'b0, 1'b0);
      run_phase(80, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
      run_phase(80, $urandom(), 1'b1, 1'b0, 1'b0);
      run_phase(80, 32'h0001_0000, 1'b0, 1'b0, 1'b1);
      run_phase(80, 32'h0000_0000, 1'b0, 1'b0, 1'b0);

      if (board.mismatches == 0 && board.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
